### hdl/assert_macros.svh
// Assertion macros used by dsp_checker.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("%m: %s failed", "label");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("%m: %s failed", "label");

`endif

### hdl/dsp_pkg.sv
// Types and constants of the shortest-path unit.
// Depends on nothing.
package dsp_pkg;

	localparam int NODE_FIELD_W   = 6;
	localparam int WEIGHT_FIELD_W = 16;
	localparam int CFG_W          = 7;
	localparam int MAX_RESULTS    = 64;
	localparam int CHAIN_AW       = 6;
	localparam int APB_AW         = 3;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNREACH = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic latch;
		logic add_edge;
		logic clear_edges;
		logic q_init;
		logic round_start;
		logic scan;
		logic settle;
		logic round_inc;
		logic edge_rd;
		logic relax;
		logic walk_start;
		logic walk_push;
		logic walk_next;
		logic emit_load;
		logic load_err;
	} dsp_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       full;
		logic       q_bad;
		logic       scan_done;
		logic       found;
		logic       rounds_done;
		logic       edge_done;
		logic       dst_reached;
		logic       walk_end;
		logic       emit_last;
		logic       out_free;
	} dsp_stat_t;

endpackage

### hdl/dsp_if.sv
// Input and output channel interfaces of the shortest-path unit.
// Depends on dsp_pkg.
interface dsp_in_if;
	import dsp_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [NODE_FIELD_W-1:0]   from_node;
	logic [NODE_FIELD_W-1:0]   to_node;
	logic [WEIGHT_FIELD_W-1:0] weight;
	logic [NODE_FIELD_W-1:0]   source_node;
	logic [NODE_FIELD_W-1:0]   dest_node;
	modport source (output valid, mode, from_node, to_node, weight, source_node, dest_node,
		input ready);
	modport sink (input valid, mode, from_node, to_node, weight, source_node, dest_node,
		output ready);
endinterface

interface dsp_out_if;
	import dsp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [NODE_FIELD_W-1:0] path_node;
	logic                    is_last;
	logic [1:0]              status;
	modport source (output valid, path_node, is_last, status, input ready);
	modport sink (input valid, path_node, is_last, status, output ready);
endinterface

### hdl/dsp_datapath.sv
// Datapath: edge store, distance, parent and path memories, scan and relax logic.
// Depends on dsp_pkg.
module dsp_datapath #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [dsp_pkg::CFG_W-1:0]         node_count,
	input  dsp_pkg::dsp_cmd_t                 cmd,
	output dsp_pkg::dsp_stat_t                stat,
	input  logic [1:0]                        in_mode,
	input  logic [dsp_pkg::NODE_FIELD_W-1:0]  in_from,
	input  logic [dsp_pkg::NODE_FIELD_W-1:0]  in_to,
	input  logic [dsp_pkg::WEIGHT_FIELD_W-1:0] in_weight,
	input  logic [dsp_pkg::NODE_FIELD_W-1:0]  in_src,
	input  logic [dsp_pkg::NODE_FIELD_W-1:0]  in_dst,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dsp_pkg::NODE_FIELD_W-1:0]  out_node,
	output logic                              out_last,
	output logic [1:0]                        out_status
);
	import dsp_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int DW  = WEIGHT_BITS + NW;
	localparam int EW  = 2 * NODE_FIELD_W + WEIGHT_BITS;

	logic [1:0]                mode_q;
	logic [NODE_FIELD_W-1:0]   from_q, to_q, src_q, dst_q;
	logic [WEIGHT_BITS-1:0]    w_q;

	logic [EW-1:0]             edge_mem [MAX_EDGES];
	logic [EW-1:0]             edge_rd_q;
	logic [ECW-1:0]            edge_count_q;
	logic [ECW-1:0]            e_idx_q;

	logic [DW-1:0]             dist_mem [MAX_NODES];
	logic [DW-1:0]             dist_rd_q;
	logic [NW-1:0]             dist_raddr;
	logic                      dist_we;
	logic [NW-1:0]             dist_waddr;
	logic [DW-1:0]             dist_wdata;

	logic [NW-1:0]             parent_mem [MAX_NODES];
	logic [NW-1:0]             parent_rd_q;

	logic [NW-1:0]             chain_mem [MAX_RESULTS];
	logic [NW-1:0]             chain_rd_q;
	logic [CHAIN_AW:0]         chain_len_q;
	logic [CHAIN_AW-1:0]       emit_idx_q;
	logic [NW-1:0]             cur_q;

	logic [MAX_NODES-1:0]      settled_q, reached_q;
	logic [NCW-1:0]            n_eff;
	logic [NCW-1:0]            round_q;
	logic [NCW-1:0]            scan_idx_q;
	logic                      scan_v_s1;
	logic [NW-1:0]             scan_node_s1;
	logic                      found_q;
	logic [DW-1:0]             best_q;
	logic [NW-1:0]             u_q;

	logic                      out_valid_q, out_last_q;
	logic [NODE_FIELD_W-1:0]   out_node_q;
	logic [1:0]                out_status_q;

	logic [NODE_FIELD_W-1:0]   e_from, e_to;
	logic [WEIGHT_BITS-1:0]    e_w;
	logic [NW-1:0]             e_v;
	logic [DW-1:0]             cand;
	logic                      eligible, better, scan_take;

	always_comb begin
		if (node_count == '0)
			n_eff = NCW'(1);
		else if (32'(node_count) > MAX_NODES)
			n_eff = NCW'(MAX_NODES);
		else
			n_eff = NCW'(node_count);
	end

	assign e_from   = edge_rd_q[EW-1 -: NODE_FIELD_W];
	assign e_to     = edge_rd_q[EW-NODE_FIELD_W-1 -: NODE_FIELD_W];
	assign e_w      = edge_rd_q[WEIGHT_BITS-1:0];
	assign e_v      = NW'(e_to);
	assign cand     = best_q + DW'(e_w);
	assign eligible = (32'(e_from) == 32'(u_q)) && (32'(e_to) < 32'(n_eff)) && !settled_q[e_v];
	assign better   = !reached_q[e_v] || (cand < dist_rd_q);
	assign scan_take = scan_v_s1 && reached_q[scan_node_s1] && !settled_q[scan_node_s1]
		&& (!found_q || dist_rd_q <= best_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= in_mode;
			from_q <= in_from;
			to_q   <= in_to;
			w_q    <= WEIGHT_BITS'(in_weight);
			src_q  <= in_src;
			dst_q  <= in_dst;
		end
	end

	// edge store
	always_ff @(posedge clk) begin
		if (cmd.add_edge)
			edge_mem[edge_count_q[EAW-1:0]] <= {from_q, to_q, w_q};
		if (cmd.edge_rd)
			edge_rd_q <= edge_mem[e_idx_q[EAW-1:0]];
	end

	// distance store
	assign dist_raddr = cmd.scan ? NW'(scan_idx_q) : e_v;
	assign dist_we    = cmd.q_init || (cmd.relax && eligible && better);
	assign dist_waddr = cmd.q_init ? NW'(src_q) : e_v;
	assign dist_wdata = cmd.q_init ? '0 : cand;

	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[dist_waddr] <= dist_wdata;
		dist_rd_q <= dist_mem[dist_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.relax && eligible && better)
			parent_mem[e_v] <= u_q;
		parent_rd_q <= parent_mem[cur_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_push)
			chain_mem[chain_len_q[CHAIN_AW-1:0]] <= cur_q;
		chain_rd_q <= chain_mem[emit_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.settle)
			best_q <= best_q;
		if (cmd.round_start)
			best_q <= '0;
		else if (scan_take)
			best_q <= dist_rd_q;
		if (scan_take)
			u_q <= scan_node_s1;
		if (cmd.walk_start)
			cur_q <= NW'(dst_q);
		else if (cmd.walk_next)
			cur_q <= parent_rd_q;
		if (cmd.walk_push && stat.walk_end)
			emit_idx_q <= chain_len_q[CHAIN_AW-1:0];
		else if (cmd.emit_load && emit_idx_q != '0)
			emit_idx_q <= emit_idx_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			e_idx_q      <= '0;
			settled_q    <= '0;
			reached_q    <= '0;
			round_q      <= '0;
			scan_idx_q   <= '0;
			scan_v_s1    <= 1'b0;
			scan_node_s1 <= '0;
			found_q      <= 1'b0;
			chain_len_q  <= '0;
		end else begin
			if (cmd.add_edge)
				edge_count_q <= edge_count_q + 1'b1;
			else if (cmd.clear_edges)
				edge_count_q <= '0;
			if (cmd.q_init) begin
				settled_q <= '0;
				reached_q <= MAX_NODES'(1) << NW'(src_q);
				round_q   <= '0;
			end
			if (cmd.round_start) begin
				scan_idx_q <= '0;
				scan_v_s1  <= 1'b0;
				found_q    <= 1'b0;
			end else if (cmd.scan) begin
				if (scan_idx_q < n_eff) begin
					scan_idx_q   <= scan_idx_q + 1'b1;
					scan_node_s1 <= NW'(scan_idx_q);
					scan_v_s1    <= 1'b1;
				end else begin
					scan_v_s1 <= 1'b0;
				end
				if (scan_take)
					found_q <= 1'b1;
			end
			if (cmd.settle) begin
				settled_q[u_q] <= 1'b1;
				e_idx_q        <= '0;
			end
			if (cmd.relax) begin
				e_idx_q <= e_idx_q + 1'b1;
				if (eligible && better)
					reached_q[e_v] <= 1'b1;
			end
			if (cmd.round_inc)
				round_q <= round_q + 1'b1;
			if (cmd.walk_start)
				chain_len_q <= '0;
			else if (cmd.walk_push)
				chain_len_q <= chain_len_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_node_q   <= NODE_FIELD_W'(chain_rd_q);
			out_last_q   <= (emit_idx_q == '0);
			out_status_q <= ST_OK;
		end else if (cmd.load_err) begin
			out_node_q   <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= (mode_q == MODE_ADD) ? ST_FULL : ST_UNREACH;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_node   = out_node_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

	assign stat.mode        = mode_q;
	assign stat.full        = (32'(edge_count_q) == MAX_EDGES);
	assign stat.q_bad       = (32'(src_q) >= 32'(n_eff)) || (32'(dst_q) >= 32'(n_eff));
	assign stat.scan_done   = (scan_idx_q == n_eff) && !scan_v_s1;
	assign stat.found       = found_q;
	assign stat.rounds_done = ((NCW+1)'(round_q) + 1'b1) >= (NCW+1)'(n_eff);
	assign stat.edge_done   = (e_idx_q >= edge_count_q);
	assign stat.dst_reached = reached_q[NW'(dst_q)];
	assign stat.walk_end    = (32'(cur_q) == 32'(src_q)) || (32'(chain_len_q) == MAX_RESULTS - 1);
	assign stat.emit_last   = (emit_idx_q == '0);
	assign stat.out_free    = !out_valid_q || out_ready;

endmodule

### hdl/dsp_ctrl.sv
// Controller state machine: sequences edge loading, the search and path output.
// Depends on dsp_pkg.
module dsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dsp_pkg::dsp_stat_t stat,
	output dsp_pkg::dsp_cmd_t  cmd
);
	import dsp_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_ERR      = 4'd2;
	localparam logic [3:0] S_ROUND    = 4'd3;
	localparam logic [3:0] S_SCAN     = 4'd4;
	localparam logic [3:0] S_EDGE_RD  = 4'd5;
	localparam logic [3:0] S_EDGE_CHK = 4'd6;
	localparam logic [3:0] S_EDGE_UPD = 4'd7;
	localparam logic [3:0] S_PATH     = 4'd8;
	localparam logic [3:0] S_PUSH     = 4'd9;
	localparam logic [3:0] S_WAIT     = 4'd10;
	localparam logic [3:0] S_EMIT_RD  = 4'd11;
	localparam logic [3:0] S_EMIT_LD  = 4'd12;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.mode)
					MODE_ADD: begin
						if (stat.full) begin
							state_d = S_ERR;
						end else begin
							cmd.add_edge = 1'b1;
							state_d      = S_IDLE;
						end
					end
					MODE_QUERY: begin
						if (stat.q_bad) begin
							state_d = S_ERR;
						end else begin
							cmd.q_init = 1'b1;
							state_d    = S_ROUND;
						end
					end
					MODE_CLEAR: begin
						cmd.clear_edges = 1'b1;
						state_d         = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.load_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_ROUND: begin
				if (stat.rounds_done) begin
					state_d = S_PATH;
				end else begin
					cmd.round_start = 1'b1;
					state_d         = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.scan_done) begin
					cmd.scan = 1'b1;
				end else if (!stat.found) begin
					state_d = S_PATH;
				end else begin
					cmd.settle = 1'b1;
					state_d    = S_EDGE_RD;
				end
			end
			S_EDGE_RD: begin
				if (stat.edge_done) begin
					cmd.round_inc = 1'b1;
					state_d       = S_ROUND;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = S_EDGE_CHK;
				end
			end
			S_EDGE_CHK: state_d = S_EDGE_UPD;
			S_EDGE_UPD: begin
				cmd.relax = 1'b1;
				state_d   = S_EDGE_RD;
			end
			S_PATH: begin
				if (!stat.dst_reached) begin
					state_d = S_ERR;
				end else begin
					cmd.walk_start = 1'b1;
					state_d        = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.walk_push = 1'b1;
				state_d       = stat.walk_end ? S_EMIT_RD : S_WAIT;
			end
			S_WAIT: begin
				cmd.walk_next = 1'b1;
				state_d       = S_PUSH;
			end
			S_EMIT_RD: state_d = S_EMIT_LD;
			S_EMIT_LD: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					state_d       = stat.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### hdl/dijkstra_shortest_path_unit.sv
// Shortest-path unit: loads directed weighted edges, answers (source, destination) queries
// with the path node by node. A query settles at most n-1 nodes, n the node count, and
// ends early when the search runs out of reachable nodes; each round is a node scan and
// an edge relax loop (read, check, update) over the stored edges, on a distance memory
// with one read and one write port. Results leave through an output register, and
// back-pressure stalls them.
// Depends on dsp_pkg, dsp_if, dsp_ctrl, dsp_datapath.
module dijkstra_shortest_path_unit #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_EDGES   = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dsp_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	dsp_in_if.sink                     in_ch,
	dsp_out_if.source                  out_ch
);
	import dsp_pkg::*;

	logic [CFG_W-1:0] node_count_q;
	dsp_cmd_t         cmd;
	dsp_stat_t        stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_count_q <= NODE_COUNT_RST;
		else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT)
			node_count_q <= pwdata[CFG_W-1:0];
	end

	dsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsp_datapath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_count (node_count_q),
		.cmd        (cmd),
		.stat       (stat),
		.in_mode    (in_ch.mode),
		.in_from    (in_ch.from_node),
		.in_to      (in_ch.to_node),
		.in_weight  (in_ch.weight),
		.in_src     (in_ch.source_node),
		.in_dst     (in_ch.dest_node),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_node   (out_ch.path_node),
		.out_last   (out_ch.is_last),
		.out_status (out_ch.status)
	);

endmodule

### hdl/dsp_checker.sv
// Port-level checks of the shortest-path unit, bound to the top level.
// Depends on dsp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [dsp_pkg::NODE_FIELD_W-1:0] path_node,
	input logic                             is_last,
	input logic [1:0]                       status
);
	import dsp_pkg::*;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status))
	`ASSERT_IMPLIES(a_err_last, clk, arst_n, out_valid && status != ST_OK, is_last)
	`ASSERT_IMPLIES(a_err_zero, clk, arst_n, out_valid && status != ST_OK, path_node == '0)
	`ASSERT_IMPLIES(a_status_code, clk, arst_n, out_valid,
		status == ST_OK || status == ST_UNREACH || status == ST_FULL)

endmodule

bind dijkstra_shortest_path_unit dsp_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.path_node (out_ch.path_node),
	.is_last   (out_ch.is_last),
	.status    (out_ch.status)
);
